/* src/pool_free_list_manager_macros.svh */
// assertion macros used by the checker of the pool free list manager
`ifndef POOL_FREE_LIST_MANAGER_MACROS_SVH
`define POOL_FREE_LIST_MANAGER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PFL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pool free list check failed");

// consequent checked in the cycle after the antecedent
`define PFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pool free list check failed");

`endif

/* src/pfl_pkg.sv */
`default_nettype none

package pfl_pkg;

  localparam int OP_W   = 2;
  localparam int LIST_W = 4;
  localparam int SLOT_W = 8;

  // command codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELINK = 2'd2;
  localparam logic [OP_W-1:0] OP_EMPTY  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LIST_W-1:0] list_index;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

endpackage

`default_nettype wire

/* src/pfl_ram.sv */
`default_nettype none

module pfl_ram #(
  parameter int DEPTH = 272,
  parameter int DW    = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/pfl_seq.sv */
`default_nettype none

module pfl_seq #(
  parameter int POOL_SLOTS = 256,
  parameter int LIST_COUNT = 16,
  localparam int NODES = POOL_SLOTS + LIST_COUNT,
  localparam int AW    = $clog2(NODES),
  localparam int NW    = $clog2(NODES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output      logic          cmd_ready_o,
  input  wire pfl_pkg::cmd_t cmd_i,
  output      logic          rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output      pfl_pkg::rsp_t rsp_o,
  output      logic [AW-1:0] next_raddr_o,
  input  wire logic [NW-1:0] next_rdata_i,
  output      logic          next_we_o,
  output      logic [AW-1:0] next_waddr_o,
  output      logic [NW-1:0] next_wdata_o,
  output      logic [AW-1:0] prev_raddr_o,
  input  wire logic [NW-1:0] prev_rdata_i,
  output      logic          prev_we_o,
  output      logic [AW-1:0] prev_waddr_o,
  output      logic [NW-1:0] prev_wdata_o
);

  localparam int LIST_CODES = 2 ** pfl_pkg::LIST_W;

  localparam logic [NW-1:0] NIL        = NW'(NODES);
  localparam logic [NW-1:0] SLOTS_NW   = NW'(POOL_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(POOL_SLOTS - 1);
  localparam logic [AW-1:0] FIRST_SENT = AW'(POOL_SLOTS);
  localparam logic [AW-1:0] LAST_NODE  = AW'(NODES - 1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_LINK  = 3'd3;
  localparam logic [2:0] ST_FIX   = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;
  localparam logic [2:0] ST_SWEEP = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       end_q, end_d;
  logic [NW-1:0]       free_head_q, free_head_d;
  pfl_pkg::cmd_t       cmd_q, cmd_d;
  pfl_pkg::rsp_t       rsp_q, rsp_d;
  logic [NW-1:0]       a_q, a_d;
  logic [NW-1:0]       b_q, b_d;

  logic [AW-1:0]       sent_tbl [LIST_COUNT > 0 ? LIST_CODES : 1];
  logic [AW-1:0]       sent_addr;
  logic                head_ok;
  logic                slot_ok;
  logic [AW-1:0]       si_addr;
  logic [NW-1:0]       sweep_next;

  // sentinel node of each list code, list codes wrap at the list count
  for (genvar g = 0; g < LIST_CODES; g++) begin : g_sent
    assign sent_tbl[g] = AW'(POOL_SLOTS + (g % LIST_COUNT));
  end

  assign sent_addr  = sent_tbl[cmd_q.list_index];
  assign head_ok    = free_head_q < SLOTS_NW;
  assign slot_ok    = 32'(cmd_q.slot_index) < 32'(POOL_SLOTS);
  assign si_addr    = AW'(cmd_q.slot_index);
  assign sweep_next = (idx_q == LAST_SLOT) ? NIL : NW'(idx_q) + NW'(1);

  // a link write to the no-node code is dropped
  function automatic logic node_ok(input logic [NW-1:0] v);
    node_ok = v < NIL;
  endfunction

  // sequencer over the two link memory ports
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    end_d        = end_q;
    free_head_d  = free_head_q;
    cmd_d        = cmd_q;
    rsp_d        = rsp_q;
    a_d          = a_q;
    b_d          = b_q;
    cmd_ready_o  = 1'b0;
    rsp_valid_o  = 1'b0;
    next_raddr_o = '0;
    prev_raddr_o = '0;
    next_we_o    = 1'b0;
    next_waddr_o = '0;
    next_wdata_o = '0;
    prev_we_o    = 1'b0;
    prev_waddr_o = '0;
    prev_wdata_o = '0;

    case (state_q)
      ST_INIT, ST_SWEEP: begin
        // one node per cycle back to its reset links
        if (idx_q < FIRST_SENT) begin
          next_we_o    = 1'b1;
          next_waddr_o = idx_q;
          next_wdata_o = sweep_next;
        end else begin
          next_we_o    = 1'b1;
          next_waddr_o = idx_q;
          next_wdata_o = NW'(idx_q);
          prev_we_o    = 1'b1;
          prev_waddr_o = idx_q;
          prev_wdata_o = NW'(idx_q);
        end
        if (idx_q == end_q) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.op)
            pfl_pkg::OP_RELINK: begin
              idx_d       = '0;
              end_d       = LAST_SLOT;
              free_head_d = '0;
              rsp_d       = '{granted: 1'b1, slot: '0};
              state_d     = ST_SWEEP;
            end
            pfl_pkg::OP_EMPTY: begin
              idx_d   = FIRST_SENT;
              end_d   = LAST_NODE;
              rsp_d   = '{granted: 1'b1, slot: '0};
              state_d = ST_SWEEP;
            end
            default: begin
              state_d = ST_READ;
            end
          endcase
        end
      end

      ST_READ: begin
        if (cmd_q.op == pfl_pkg::OP_ALLOC) begin
          // free head and the tail of the target list
          next_raddr_o = AW'(free_head_q);
          prev_raddr_o = sent_addr;
          if (head_ok) begin
            rsp_d   = '{granted: 1'b1, slot: pfl_pkg::SLOT_W'(free_head_q)};
            state_d = ST_LINK;
          end else begin
            rsp_d   = '{granted: 1'b0, slot: '0};
            state_d = ST_RESP;
          end
        end else begin
          // both neighbors of the freed slot
          next_raddr_o = si_addr;
          prev_raddr_o = si_addr;
          if (slot_ok) begin
            rsp_d   = '{granted: 1'b1, slot: cmd_q.slot_index};
            state_d = ST_LINK;
          end else begin
            rsp_d   = '{granted: 1'b0, slot: '0};
            state_d = ST_RESP;
          end
        end
      end

      ST_LINK: begin
        if (cmd_q.op == pfl_pkg::OP_ALLOC) begin
          // pop head, link the new node after the old tail
          a_d          = prev_rdata_i;
          b_d          = free_head_q;
          free_head_d  = next_rdata_i;
          prev_we_o    = 1'b1;
          prev_waddr_o = AW'(free_head_q);
          prev_wdata_o = prev_rdata_i;
          next_we_o    = 1'b1;
          next_waddr_o = AW'(free_head_q);
          next_wdata_o = NW'(sent_addr);
        end else begin
          // bridge the neighbors over the freed slot
          a_d          = next_rdata_i;
          b_d          = prev_rdata_i;
          prev_we_o    = node_ok(next_rdata_i);
          prev_waddr_o = AW'(next_rdata_i);
          prev_wdata_o = prev_rdata_i;
          next_we_o    = node_ok(prev_rdata_i);
          next_waddr_o = AW'(prev_rdata_i);
          next_wdata_o = next_rdata_i;
        end
        state_d = ST_FIX;
      end

      ST_FIX: begin
        if (cmd_q.op == pfl_pkg::OP_ALLOC) begin
          // old tail and sentinel point at the new node
          next_we_o    = node_ok(a_q);
          next_waddr_o = AW'(a_q);
          next_wdata_o = b_q;
          prev_we_o    = 1'b1;
          prev_waddr_o = sent_addr;
          prev_wdata_o = b_q;
        end else begin
          // push the freed slot on the free chain
          next_we_o    = 1'b1;
          next_waddr_o = si_addr;
          next_wdata_o = free_head_q;
          free_head_d  = NW'(cmd_q.slot_index);
        end
        rsp_valid_o = 1'b1;
        state_d     = rsp_ready_i ? ST_IDLE : ST_RESP;
      end

      ST_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o = rsp_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      idx_q       <= '0;
      end_q       <= LAST_NODE;
      free_head_q <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      free_head_q <= free_head_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rsp_q <= rsp_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

endmodule

`default_nettype wire

/* src/pool_free_list_manager.sv */
// Pool free list manager: hands out slots of a fixed pool and files each
// allocated slot on one of several circular class lists.
// Input channel (in_valid_i / in_ready_o) takes one command item: op_i
// selects allocate, free, relink all slots as free, or empty all lists;
// list_index_i names the class list, slot_index_i the slot to free.
// Output channel (out_valid_o / out_ready_i) returns one item per command:
// granted_o and slot_o (slot allocated or freed, zero otherwise).
// Allocate and free pass through read, link and fix states to a result, and
// the block takes no new item until it is back in idle; the link memories
// have one read and one write port each, and each command needs a read, then
// writes in the link and fix states. A failed allocate or out-of-pool free
// skips the link and fix states. Relink rewrites the POOL_SLOTS slot links
// and empty the LIST_COUNT sentinel links, one node written per cycle.
// After reset the block sweeps all POOL_SLOTS + LIST_COUNT link entries,
// one per cycle, with in_ready_o low; then every slot is free and every
// list is empty.
// A finished result waits in an output register; while the receiver
// stalls, the next item is accepted and worked on up to its own result.
`default_nettype none

module pool_free_list_manager #(
  parameter int POOL_SLOTS = 256,
  parameter int LIST_COUNT = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [pfl_pkg::OP_W-1:0]     op_i,
  input  wire logic [pfl_pkg::LIST_W-1:0]   list_index_i,
  input  wire logic [pfl_pkg::SLOT_W-1:0]   slot_index_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         granted_o,
  output      logic [pfl_pkg::SLOT_W-1:0]   slot_o
);

  localparam int NODES = POOL_SLOTS + LIST_COUNT;
  localparam int AW    = $clog2(NODES);
  localparam int NW    = $clog2(NODES + 1);

  pfl_pkg::cmd_t cmd;
  pfl_pkg::rsp_t rsp;
  logic          rsp_valid;
  logic          rsp_ready;
  pfl_pkg::rsp_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic [AW-1:0] next_raddr, next_waddr, prev_raddr, prev_waddr;
  logic [NW-1:0] next_rdata, next_wdata, prev_rdata, prev_wdata;
  logic          next_we, prev_we;

  assign cmd = '{op: op_i, list_index: list_index_i, slot_index: slot_index_i};

  pfl_seq #(
    .POOL_SLOTS(POOL_SLOTS),
    .LIST_COUNT(LIST_COUNT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (in_valid_i),
    .cmd_ready_o  (in_ready_o),
    .cmd_i        (cmd),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_o        (rsp),
    .next_raddr_o (next_raddr),
    .next_rdata_i (next_rdata),
    .next_we_o    (next_we),
    .next_waddr_o (next_waddr),
    .next_wdata_o (next_wdata),
    .prev_raddr_o (prev_raddr),
    .prev_rdata_i (prev_rdata),
    .prev_we_o    (prev_we),
    .prev_waddr_o (prev_waddr),
    .prev_wdata_o (prev_wdata)
  );

  // forward links, free chain and list order
  pfl_ram #(
    .DEPTH(NODES),
    .DW   (NW)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  // backward links of the class lists
  pfl_ram #(
    .DEPTH(NODES),
    .DW   (NW)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  // output register, loads when empty or being drained
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
      out_d       = rsp;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign granted_o   = out_q.granted;
  assign slot_o      = out_q.slot;

endmodule

`default_nettype wire

/* src/pfl_checker.sv */
`default_nettype none
`include "pool_free_list_manager_macros.svh"

module pfl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       granted_i,
  input wire logic [7:0] slot_i
);

  // one item at a time: busy right after an item is taken
  `PFL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a refused command never names a slot
  `PFL_ASSERT_SAME(a_refused_no_slot, clk_i, rst_ni, out_valid_i && !granted_i, slot_i == 8'd0)

  // a stalled result stays offered
  `PFL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled result keeps its payload
  `PFL_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(slot_i) && $stable(granted_i))

endmodule

bind pool_free_list_manager pfl_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .granted_i   (granted_o),
  .slot_i      (slot_o)
);

`default_nettype wire
